FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/hc_pkg.sv
package hc_pkg;

    typedef struct packed {
        logic [7:0] char_first;
        logic [7:0] char_second;
    } t_pair;

    typedef struct packed {
        logic [7:0] out_first;
        logic [7:0] out_second;
        logic       key_error;
    } t_result;

    // Working key matrix, row 0 is (e00, e01), row 1 is (e10, e11)
    typedef struct packed {
        logic       m27;
        logic [4:0] e00;
        logic [4:0] e01;
        logic [4:0] e10;
        logic [4:0] e11;
        logic       key_error;
    } t_key;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS  = 3'd0;
    localparam t_cfg_idx CFG_DECRYPT  = 3'd1;
    localparam t_cfg_idx CFG_KEY_0    = 3'd2;
    localparam t_cfg_idx CFG_KEY_1    = 3'd3;
    localparam t_cfg_idx CFG_KEY_2    = 3'd4;
    localparam t_cfg_idx CFG_KEY_3    = 3'd5;

    localparam logic [4:0] MOD_26 = 5'd26;
    localparam logic [4:0] MOD_27 = 5'd27;

    // ceil(2^16 / m): exact quotient for any value below 2048
    localparam logic [11:0] RECIP_26 = 12'd2521;
    localparam logic [11:0] RECIP_27 = 12'd2428;

    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_Y     = 8'h79;
    localparam logic [7:0] CHAR_Z     = 8'h7a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [3:0] KeySettle = 4'd8;

    function automatic logic [4:0] mod_val(input logic m27);
        return m27 ? MOD_27 : MOD_26;
    endfunction

    function automatic logic [6:0] mod_quot(input logic [10:0] x, input logic m27);
        logic [22:0] prod;
        prod = 23'(x * (m27 ? RECIP_27 : RECIP_26));
        return prod[22:16];
    endfunction

    function automatic logic [4:0] mod_rem(input logic [10:0] x, input logic [6:0] q,
                                           input logic m27);
        logic [10:0] qm;
        logic [10:0] r;
        qm = 11'(q * mod_val(m27));
        r  = x - qm;
        return r[4:0];
    endfunction

    function automatic logic [4:0] to_symbol(input logic [7:0] c, input logic m27);
        logic [7:0] off;
        off = c - CHAR_A;
        if (c >= CHAR_A && c <= CHAR_Y) begin
            return off[4:0] + 5'd1;
        end else if (c == CHAR_Z) begin
            return m27 ? 5'd26 : 5'd0;
        end else begin
            return 5'd0;
        end
    endfunction

    function automatic logic [7:0] to_char(input logic [4:0] v, input logic m27);
        if (v == 5'd0) begin
            return m27 ? CHAR_SPACE : CHAR_Z;
        end else begin
            return CHAR_A - 8'd1 + {3'b000, v};
        end
    endfunction

    // Multiplicative inverse, 0 when none exists
    function automatic logic [4:0] inv_lookup(input logic [4:0] d, input logic m27);
        logic [4:0] r;
        r = 5'd0;
        if (m27) begin
            case (d)
                5'd1:    r = 5'd1;
                5'd2:    r = 5'd14;
                5'd4:    r = 5'd7;
                5'd5:    r = 5'd11;
                5'd7:    r = 5'd4;
                5'd8:    r = 5'd17;
                5'd10:   r = 5'd19;
                5'd11:   r = 5'd5;
                5'd13:   r = 5'd25;
                5'd14:   r = 5'd2;
                5'd16:   r = 5'd22;
                5'd17:   r = 5'd8;
                5'd19:   r = 5'd10;
                5'd20:   r = 5'd23;
                5'd22:   r = 5'd16;
                5'd23:   r = 5'd20;
                5'd25:   r = 5'd13;
                5'd26:   r = 5'd26;
                default: r = 5'd0;
            endcase
        end else begin
            case (d)
                5'd1:    r = 5'd1;
                5'd3:    r = 5'd9;
                5'd5:    r = 5'd21;
                5'd7:    r = 5'd15;
                5'd9:    r = 5'd3;
                5'd11:   r = 5'd19;
                5'd15:   r = 5'd7;
                5'd17:   r = 5'd23;
                5'd19:   r = 5'd11;
                5'd21:   r = 5'd5;
                5'd23:   r = 5'd17;
                5'd25:   r = 5'd25;
                default: r = 5'd0;
            endcase
        end
        return r;
    endfunction

endpackage

FILE: rtl/hc_keygen.sv
module hc_keygen import hc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_cfg_idx   i_cfg_index,
    input  logic [4:0] i_cfg_data,
    output t_key       o_key,
    output logic       o_settling
);

    logic [4:0] r_modulus;
    logic       r_decrypt;
    logic [4:0] r_key [4];
    logic [3:0] r_settle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_26;
            r_decrypt <= 1'b0;
            r_key[0]  <= 5'd11;
            r_key[1]  <= 5'd15;
            r_key[2]  <= 5'd16;
            r_key[3]  <= 5'd9;
            r_settle  <= KeySettle;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS: r_modulus <= i_cfg_data;
                CFG_DECRYPT: r_decrypt <= i_cfg_data[0];
                CFG_KEY_0:   r_key[0]  <= i_cfg_data;
                CFG_KEY_1:   r_key[1]  <= i_cfg_data;
                CFG_KEY_2:   r_key[2]  <= i_cfg_data;
                CFG_KEY_3:   r_key[3]  <= i_cfg_data;
                default: ;
            endcase
            r_settle <= KeySettle;
        end else if (r_settle != 4'd0) begin
            r_settle <= r_settle - 4'd1;
        end
    end

    assign o_settling = (r_settle != 4'd0);

    // Free-running derivation chain; every stage follows the settled registers
    logic       r_m27;
    logic [4:0] r_ka, r_kb, r_kc, r_kd;
    logic [9:0] r_pad, r_pbc;
    logic [6:0] r_qad, r_qbc;
    logic [4:0] r_det;
    logic [4:0] r_inv, r_nb, r_nc;
    logic [9:0] r_prod [4];
    logic [6:0] r_quot [4];
    t_key       r_out;

    logic       n_m27;
    logic [4:0] n_mv, n_rad, n_rbc;
    logic [4:0] n_k [4];

    always_comb begin
        n_m27 = (r_modulus >= MOD_27);
        n_mv  = mod_val(n_m27);
        for (int i = 0; i < 4; i++) begin
            n_k[i] = (r_key[i] >= n_mv) ? r_key[i] - n_mv : r_key[i];
        end
        n_rad = mod_rem({1'b0, r_pad}, r_qad, r_m27);
        n_rbc = mod_rem({1'b0, r_pbc}, r_qbc, r_m27);
    end

    always_ff @(posedge i_clk) begin
        r_m27 <= n_m27;
        r_ka  <= n_k[0];
        r_kc  <= n_k[1];
        r_kb  <= n_k[2];
        r_kd  <= n_k[3];

        r_pad <= 10'(r_ka * r_kd);
        r_pbc <= 10'(r_kb * r_kc);

        r_qad <= mod_quot({1'b0, r_pad}, r_m27);
        r_qbc <= mod_quot({1'b0, r_pbc}, r_m27);

        r_det <= (n_rad >= n_rbc) ? n_rad - n_rbc : n_rad + mod_val(r_m27) - n_rbc;

        r_inv <= inv_lookup(r_det, r_m27);
        r_nb  <= (r_kb == 5'd0) ? 5'd0 : mod_val(r_m27) - r_kb;
        r_nc  <= (r_kc == 5'd0) ? 5'd0 : mod_val(r_m27) - r_kc;

        r_prod[0] <= 10'(r_inv * r_kd);
        r_prod[1] <= 10'(r_inv * r_nb);
        r_prod[2] <= 10'(r_inv * r_nc);
        r_prod[3] <= 10'(r_inv * r_ka);

        for (int i = 0; i < 4; i++) begin
            r_quot[i] <= mod_quot({1'b0, r_prod[i]}, r_m27);
        end

        r_out.m27       <= r_m27;
        r_out.key_error <= (r_inv == 5'd0);
        if (r_decrypt) begin
            r_out.e00 <= mod_rem({1'b0, r_prod[0]}, r_quot[0], r_m27);
            r_out.e01 <= mod_rem({1'b0, r_prod[1]}, r_quot[1], r_m27);
            r_out.e10 <= mod_rem({1'b0, r_prod[2]}, r_quot[2], r_m27);
            r_out.e11 <= mod_rem({1'b0, r_prod[3]}, r_quot[3], r_m27);
        end else begin
            r_out.e00 <= r_ka;
            r_out.e01 <= r_kb;
            r_out.e10 <= r_kc;
            r_out.e11 <= r_kd;
        end
    end

    assign o_key = r_out;

endmodule

FILE: rtl/hc_datapath.sv
module hc_datapath import hc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_pair   i_pair,
    input  t_key    i_key,
    output logic    o_valid,
    output t_result o_result
);

    logic [4:0]  r_v;
    logic [4:0]  r_x0, r_x1;
    logic [10:0] r_s0, r_s1;
    logic [6:0]  r_q0, r_q1;
    logic [10:0] r_s0_d, r_s1_d;
    logic [4:0]  r_y0, r_y1;
    t_result     r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 5'd0;
        end else begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // symbol lookup
        r_x0 <= to_symbol(i_pair.char_first, i_key.m27);
        r_x1 <= to_symbol(i_pair.char_second, i_key.m27);

        // row products
        r_s0 <= 11'(i_key.e00 * r_x0) + 11'(i_key.e01 * r_x1);
        r_s1 <= 11'(i_key.e10 * r_x0) + 11'(i_key.e11 * r_x1);

        // reduction, quotient then remainder
        r_q0   <= mod_quot(r_s0, i_key.m27);
        r_q1   <= mod_quot(r_s1, i_key.m27);
        r_s0_d <= r_s0;
        r_s1_d <= r_s1;

        r_y0 <= mod_rem(r_s0_d, r_q0, i_key.m27);
        r_y1 <= mod_rem(r_s1_d, r_q1, i_key.m27);

        if (i_key.key_error) begin
            r_res.out_first  <= 8'd0;
            r_res.out_second <= 8'd0;
            r_res.key_error  <= 1'b1;
        end else begin
            r_res.out_first  <= to_char(r_y0, i_key.m27);
            r_res.out_second <= to_char(r_y1, i_key.m27);
            r_res.key_error  <= 1'b0;
        end
    end

    assign o_valid  = r_v[4];
    assign o_result = r_res;

endmodule

FILE: rtl/hill_cipher_2x2_pair.sv
// Channel  | Handshake                        | Carries
// ---------+----------------------------------+------------------------------
// pair in  | start, busy (taken: start&!busy) | i_pair (char_first/second)
// cfg      | i_cfg_valid, o_cfg_ready         | i_cfg_index, i_cfg_data
// result   | o_valid strobe, one cycle        | o_result (chars, key_error)
//
// One pair per cycle while busy is low; each word taken passes through the
// five-stage symbol/multiply/quotient/remainder/char pipe to o_result.
// After reset and after every config write busy stays high while the key
// derivation chain (determinant, inverse, adjugate) settles.
// Results cannot be stalled; the pipe never holds a word back.
`include "assert_macros.svh"

module hill_cipher_2x2_pair import hc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_idx   i_cfg_index,
    input  logic [4:0] i_cfg_data,
    input  t_pair      i_pair,
    output logic       o_valid,
    output t_result    o_result
);

    t_key key;
    logic settling;
    logic cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;
    assign busy        = settling;

    hc_keygen u_keygen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key),
        .o_settling  (settling)
    );

    hc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start & ~busy),
        .i_pair   (i_pair),
        .i_key    (key),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    `ASSERT_NEXT(a_cfg_blocks, cfg_we, busy)
    `ASSERT_IMPL(a_latency, start && !busy, ##5 o_valid)
    `ASSERT_IMPL(a_err_zero, o_valid && o_result.key_error,
                 o_result.out_first == 8'd0 && o_result.out_second == 8'd0)
    `ASSERT_IMPL(a_out_charset, o_valid && !o_result.key_error,
                 (o_result.out_first >= CHAR_A && o_result.out_first <= CHAR_Z) ||
                 o_result.out_first == CHAR_SPACE)

endmodule
